### rtl/bci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Barycentric color interpolation package
// Shared types and constants for the interpolation pipeline.
// ----------------------------------------------------------------------------
package bci_pkg;

    // Color channels per item (red, green, blue, alpha) and spatial axes.
    localparam int LANES = 4;
    localparam int AXES  = 3;

    // Channel index of alpha, the only channel that may be reversed.
    localparam int ALPHA_LANE = 3;

    // Lanes that are full scale in the pink fallback color (R, B and A).
    localparam logic [LANES-1:0] PINK_FULL = 4'b1101;

    // Per-item flags that follow the quotient through the divider stages.
    typedef struct packed {
        logic             pink;
        logic             degen;
        logic [LANES-1:0] zero;
        logic [LANES-1:0] sat;
    } bci_ctl_t;

endpackage
`default_nettype wire

### rtl/bci_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Divider step stage
// One restoring division step for all four color lanes, with its register.
// ----------------------------------------------------------------------------
module bci_div_step
    import bci_pkg::*;
#(
    parameter int N_W  = 83,
    parameter int D_W  = 72,
    parameter int Q_W  = 8,
    parameter int STEP = 7
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          vld_in,
    input  wire bci_ctl_t                      ctl_in,
    input  wire logic [D_W-1:0]                den_in,
    input  wire logic [LANES-1:0][N_W-1:0]     rem_in,
    input  wire logic [LANES-1:0][Q_W-1:0]     quo_in,
    output logic                               vld_out,
    output bci_ctl_t                           ctl_out,
    output logic [D_W-1:0]                     den_out,
    output logic [LANES-1:0][N_W-1:0]          rem_out,
    output logic [LANES-1:0][Q_W-1:0]          quo_out
);

    logic                          vld_reg;
    bci_ctl_t                      ctl_reg;
    logic [D_W-1:0]                den_reg;
    logic [LANES-1:0][N_W-1:0]     rem_reg;
    logic [LANES-1:0][N_W-1:0]     rem_next;
    logic [LANES-1:0][Q_W-1:0]     quo_reg;
    logic [LANES-1:0][Q_W-1:0]     quo_next;
    logic [N_W-1:0]                den_shift;

    // The remainder stays below the divisor shifted one place further up, so
    // a single compare and subtract settles this quotient bit.
    always_comb
    begin
        den_shift = N_W'(den_in) << STEP;
        for (int k = 0; k < LANES; k++)
        begin
            quo_next[k] = quo_in[k];
            if (rem_in[k] >= den_shift)
            begin
                rem_next[k]       = rem_in[k] - den_shift;
                quo_next[k][STEP] = 1'b1;
            end
            else
            begin
                rem_next[k]       = rem_in[k];
                quo_next[k][STEP] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_in;
            den_reg <= den_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign vld_out = vld_reg;
    assign ctl_out = ctl_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule
`default_nettype wire

### rtl/barycentric_color_interp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Barycentric color interpolation core
// Blends three corner colors at a sample point with least-squares weights.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload
//  -------   ----------------------   ---------------------------------------
//  input     in_valid / in_stall      corner positions, corner colors,
//                                     triangle_valid
//  output    out_valid / out_stall    out_red, out_green, out_blue,
//                                     out_alpha, degenerate
//  config    cfg_valid / cfg_ready    reverse_alpha
//
//  The pipeline holds COLOR_BITS + 7 register stages and forms the rounded
//  color quotient in a one-bit-per-stage restoring divider. One item is
//  accepted per cycle while the first stage is not held by a stall.
//  Reset clears only the stage valid bits and sets reverse_alpha to one.
//  A stall only holds the stages that are full behind a full stage, so empty
//  stages keep filling and the input is taken while a result waits.
//
module barycentric_color_interp_core
    import bci_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 8
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [3*COORD_BITS-1:0]   corner_a_pos,
    input  wire logic [3*COORD_BITS-1:0]   corner_b_pos,
    input  wire logic [3*COORD_BITS-1:0]   corner_c_pos,
    input  wire logic [3*COORD_BITS-1:0]   sample_pos,
    input  wire logic [4*COLOR_BITS-1:0]   corner_a_rgba,
    input  wire logic [4*COLOR_BITS-1:0]   corner_b_rgba,
    input  wire logic [4*COLOR_BITS-1:0]   corner_c_rgba,
    input  wire logic                      triangle_valid,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [COLOR_BITS-1:0]          out_red,
    output logic [COLOR_BITS-1:0]          out_green,
    output logic [COLOR_BITS-1:0]          out_blue,
    output logic [COLOR_BITS-1:0]          out_alpha,
    output logic                           degenerate,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      reverse_alpha
);

    // Widths of the exact integer datapath. Edge vectors need two bits over
    // a coordinate, dot products take twice that width, and
    // the determinant terms are products of two dot products.
    localparam int DIFF_W = COORD_BITS + 2;
    localparam int DOT_W  = 2 * COORD_BITS + 4;
    localparam int PROD_W = 2 * DOT_W;
    localparam int CD_W   = COLOR_BITS + 1;
    localparam int T_W    = PROD_W + COLOR_BITS + 3;
    localparam int N_W    = T_W + 1;
    localparam int D_W    = PROD_W;
    localparam int NS     = COLOR_BITS + 7;

    localparam logic [COLOR_BITS-1:0] CMAX = {COLOR_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Flow control: a stage may load when it is empty or when the stage
    // after it loads in the same cycle.
    // ------------------------------------------------------------------
    logic [NS-1:0] stg_vld;
    logic [NS-1:0] stg_en;

    always_comb
    begin
        stg_en[NS-1] = !stg_vld[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stg_en[i] = !stg_vld[i] || stg_en[i+1];
        end
    end

    assign in_stall = !stg_en[0];

    // ------------------------------------------------------------------
    // Configuration register. Writes are always taken.
    // ------------------------------------------------------------------
    logic reverse_alpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_alpha_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reverse_alpha_reg <= reverse_alpha;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: translate so that corner C is the origin.
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] ax [AXES];
    logic signed [COORD_BITS-1:0] bx [AXES];
    logic signed [COORD_BITS-1:0] cx [AXES];
    logic signed [COORD_BITS-1:0] px [AXES];
    logic signed [DIFF_W-1:0]     s1_a_next [AXES];
    logic signed [DIFF_W-1:0]     s1_b_next [AXES];
    logic signed [DIFF_W-1:0]     s1_p_next [AXES];

    logic                         s1_vld_reg;
    logic signed [DIFF_W-1:0]     s1_a_reg [AXES];
    logic signed [DIFF_W-1:0]     s1_b_reg [AXES];
    logic signed [DIFF_W-1:0]     s1_p_reg [AXES];
    logic [4*COLOR_BITS-1:0]      s1_col_a_reg;
    logic [4*COLOR_BITS-1:0]      s1_col_b_reg;
    logic [4*COLOR_BITS-1:0]      s1_col_c_reg;
    logic                         s1_tv_reg;

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            ax[k] = signed'(corner_a_pos[k*COORD_BITS +: COORD_BITS]);
            bx[k] = signed'(corner_b_pos[k*COORD_BITS +: COORD_BITS]);
            cx[k] = signed'(corner_c_pos[k*COORD_BITS +: COORD_BITS]);
            px[k] = signed'(sample_pos[k*COORD_BITS +: COORD_BITS]);
            s1_a_next[k] = DIFF_W'(ax[k]) - DIFF_W'(cx[k]);
            s1_b_next[k] = DIFF_W'(bx[k]) - DIFF_W'(cx[k]);
            s1_p_next[k] = DIFF_W'(px[k]) - DIFF_W'(cx[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the five dot products. The projection onto the triangle
    // plane leaves A'.P' and B'.P' unchanged, so it needs no hardware.
    // ------------------------------------------------------------------
    logic signed [DOT_W-1:0] ea [AXES];
    logic signed [DOT_W-1:0] eb [AXES];
    logic signed [DOT_W-1:0] ep [AXES];
    logic signed [DOT_W-1:0] s2_aa_next, s2_bb_next, s2_ab_next, s2_am_next, s2_bm_next;

    logic                    s2_vld_reg;
    logic signed [DOT_W-1:0] s2_aa_reg, s2_bb_reg, s2_ab_reg, s2_am_reg, s2_bm_reg;
    logic [4*COLOR_BITS-1:0] s2_col_a_reg, s2_col_b_reg, s2_col_c_reg;
    logic                    s2_tv_reg;

    always_comb
    begin
        s2_aa_next = '0;
        s2_bb_next = '0;
        s2_ab_next = '0;
        s2_am_next = '0;
        s2_bm_next = '0;
        for (int k = 0; k < AXES; k++)
        begin
            ea[k] = DOT_W'(s1_a_reg[k]);
            eb[k] = DOT_W'(s1_b_reg[k]);
            ep[k] = DOT_W'(s1_p_reg[k]);
            s2_aa_next = s2_aa_next + ea[k] * ea[k];
            s2_bb_next = s2_bb_next + eb[k] * eb[k];
            s2_ab_next = s2_ab_next + ea[k] * eb[k];
            s2_am_next = s2_am_next + ea[k] * ep[k];
            s2_bm_next = s2_bm_next + eb[k] * ep[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the six products behind the determinant and numerators.
    // ------------------------------------------------------------------
    logic                     s3_vld_reg;
    logic signed [PROD_W-1:0] s3_aabb_reg, s3_abab_reg, s3_ambb_reg;
    logic signed [PROD_W-1:0] s3_bmab_reg, s3_bmaa_reg, s3_amab_reg;
    logic [4*COLOR_BITS-1:0]  s3_col_a_reg, s3_col_b_reg, s3_col_c_reg;
    logic                     s3_tv_reg;

    // ------------------------------------------------------------------
    // Stage 4: determinant, weight numerators and color differences.
    // ------------------------------------------------------------------
    logic signed [CD_W-1:0]   s4_d1_next [LANES];
    logic signed [CD_W-1:0]   s4_d2_next [LANES];
    logic signed [CD_W-1:0]   s4_c3_next [LANES];

    logic                     s4_vld_reg;
    logic signed [PROD_W-1:0] s4_det_reg, s4_na_reg, s4_nb_reg;
    logic signed [CD_W-1:0]   s4_d1_reg [LANES];
    logic signed [CD_W-1:0]   s4_d2_reg [LANES];
    logic signed [CD_W-1:0]   s4_c3_reg [LANES];
    logic                     s4_tv_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            s4_c3_next[k] = CD_W'(s3_col_c_reg[k*COLOR_BITS +: COLOR_BITS]);
            s4_d1_next[k] = CD_W'(s3_col_a_reg[k*COLOR_BITS +: COLOR_BITS])
                          - CD_W'(s3_col_c_reg[k*COLOR_BITS +: COLOR_BITS]);
            s4_d2_next[k] = CD_W'(s3_col_b_reg[k*COLOR_BITS +: COLOR_BITS])
                          - CD_W'(s3_col_c_reg[k*COLOR_BITS +: COLOR_BITS]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scaled channel value t = c3*det + na*(c1-c3) + nb*(c2-c3).
    // ------------------------------------------------------------------
    logic signed [T_W-1:0]    s5_t_next [LANES];
    logic                     s4_det_zero;
    bci_ctl_t                 s5_ctl_next;

    logic                     s5_vld_reg;
    logic signed [T_W-1:0]    s5_t_reg [LANES];
    logic signed [PROD_W-1:0] s5_det_reg;
    bci_ctl_t                 s5_ctl_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            s5_t_next[k] = T_W'(s4_det_reg) * T_W'(s4_c3_reg[k])
                         + T_W'(s4_na_reg) * T_W'(s4_d1_reg[k])
                         + T_W'(s4_nb_reg) * T_W'(s4_d2_reg[k]);
        end
        s4_det_zero       = (s4_det_reg == '0);
        s5_ctl_next       = '0;
        s5_ctl_next.pink  = !s4_tv_reg || s4_det_zero;
        s5_ctl_next.degen = s4_tv_reg && s4_det_zero;
    end

    // ------------------------------------------------------------------
    // Stage 6: set up the rounded division (2t + det) / (2det) and flag the
    // lanes that clamp to zero or saturate before the quotient is formed.
    // ------------------------------------------------------------------
    logic [D_W-1:0]               s6_den_next;
    logic [LANES-1:0][N_W-1:0]    s6_rem_next;
    bci_ctl_t                     s6_ctl_next;

    logic                         s6_vld_reg;
    logic [D_W-1:0]               s6_den_reg;
    logic [LANES-1:0][N_W-1:0]    s6_rem_reg;
    bci_ctl_t                     s6_ctl_reg;

    always_comb
    begin
        s6_den_next = {s5_det_reg[D_W-2:0], 1'b0};
        s6_ctl_next = s5_ctl_reg;
        for (int k = 0; k < LANES; k++)
        begin
            s6_rem_next[k] = (N_W'(s5_t_reg[k]) << 1) + N_W'(s5_det_reg);
            s6_ctl_next.zero[k] = s5_t_reg[k][T_W-1] || (s5_t_reg[k] == '0);
            s6_ctl_next.sat[k]  = s6_rem_next[k] >= (N_W'(s6_den_next) << COLOR_BITS);
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, most significant bit first.
    // ------------------------------------------------------------------
    logic [COLOR_BITS:0]              dv_vld;
    bci_ctl_t                         dv_ctl [COLOR_BITS+1];
    logic [D_W-1:0]                   dv_den [COLOR_BITS+1];
    logic [LANES-1:0][N_W-1:0]        dv_rem [COLOR_BITS+1];
    logic [LANES-1:0][COLOR_BITS-1:0] dv_quo [COLOR_BITS+1];

    assign dv_vld[0] = s6_vld_reg;
    assign dv_ctl[0] = s6_ctl_reg;
    assign dv_den[0] = s6_den_reg;
    assign dv_rem[0] = s6_rem_reg;
    assign dv_quo[0] = '0;

    for (genvar i = 0; i < COLOR_BITS; i++)
    begin : g_div
        bci_div_step #(
            .N_W  (N_W),
            .D_W  (D_W),
            .Q_W  (COLOR_BITS),
            .STEP (COLOR_BITS - 1 - i)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (stg_en[6+i]),
            .vld_in  (dv_vld[i]),
            .ctl_in  (dv_ctl[i]),
            .den_in  (dv_den[i]),
            .rem_in  (dv_rem[i]),
            .quo_in  (dv_quo[i]),
            .vld_out (dv_vld[i+1]),
            .ctl_out (dv_ctl[i+1]),
            .den_out (dv_den[i+1]),
            .rem_out (dv_rem[i+1]),
            .quo_out (dv_quo[i+1])
        );
        assign stg_vld[6+i] = dv_vld[i+1];
    end

    // ------------------------------------------------------------------
    // Output stage: pick pink, zero, full scale or the quotient, then apply
    // the alpha reversal, which also applies to pink.
    // ------------------------------------------------------------------
    logic [LANES-1:0][COLOR_BITS-1:0] out_col_next;
    bci_ctl_t                         fin_ctl;

    logic                             out_vld_reg;
    logic [LANES-1:0][COLOR_BITS-1:0] out_col_reg;
    logic                             out_degen_reg;

    always_comb
    begin
        fin_ctl = dv_ctl[COLOR_BITS];
        for (int k = 0; k < LANES; k++)
        begin
            if (fin_ctl.pink)
            begin
                out_col_next[k] = PINK_FULL[k] ? CMAX : '0;
            end
            else if (fin_ctl.zero[k])
            begin
                out_col_next[k] = '0;
            end
            else if (fin_ctl.sat[k])
            begin
                out_col_next[k] = CMAX;
            end
            else
            begin
                out_col_next[k] = dv_quo[COLOR_BITS][k];
            end
        end
        if (reverse_alpha_reg)
        begin
            out_col_next[ALPHA_LANE] = ~out_col_next[ALPHA_LANE];
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits.
    // ------------------------------------------------------------------
    assign stg_vld[0]    = s1_vld_reg;
    assign stg_vld[1]    = s2_vld_reg;
    assign stg_vld[2]    = s3_vld_reg;
    assign stg_vld[3]    = s4_vld_reg;
    assign stg_vld[4]    = s5_vld_reg;
    assign stg_vld[5]    = s6_vld_reg;
    assign stg_vld[NS-1] = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (stg_en[0])
            begin
                s1_vld_reg <= in_valid;
            end
            if (stg_en[1])
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (stg_en[2])
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (stg_en[3])
            begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (stg_en[4])
            begin
                s5_vld_reg <= s4_vld_reg;
            end
            if (stg_en[5])
            begin
                s6_vld_reg <= s5_vld_reg;
            end
            if (stg_en[NS-1])
            begin
                out_vld_reg <= dv_vld[COLOR_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            s1_a_reg     <= s1_a_next;
            s1_b_reg     <= s1_b_next;
            s1_p_reg     <= s1_p_next;
            s1_col_a_reg <= corner_a_rgba;
            s1_col_b_reg <= corner_b_rgba;
            s1_col_c_reg <= corner_c_rgba;
            s1_tv_reg    <= triangle_valid;
        end
        if (stg_en[1])
        begin
            s2_aa_reg    <= s2_aa_next;
            s2_bb_reg    <= s2_bb_next;
            s2_ab_reg    <= s2_ab_next;
            s2_am_reg    <= s2_am_next;
            s2_bm_reg    <= s2_bm_next;
            s2_col_a_reg <= s1_col_a_reg;
            s2_col_b_reg <= s1_col_b_reg;
            s2_col_c_reg <= s1_col_c_reg;
            s2_tv_reg    <= s1_tv_reg;
        end
        if (stg_en[2])
        begin
            s3_aabb_reg  <= PROD_W'(s2_aa_reg) * PROD_W'(s2_bb_reg);
            s3_abab_reg  <= PROD_W'(s2_ab_reg) * PROD_W'(s2_ab_reg);
            s3_ambb_reg  <= PROD_W'(s2_am_reg) * PROD_W'(s2_bb_reg);
            s3_bmab_reg  <= PROD_W'(s2_bm_reg) * PROD_W'(s2_ab_reg);
            s3_bmaa_reg  <= PROD_W'(s2_bm_reg) * PROD_W'(s2_aa_reg);
            s3_amab_reg  <= PROD_W'(s2_am_reg) * PROD_W'(s2_ab_reg);
            s3_col_a_reg <= s2_col_a_reg;
            s3_col_b_reg <= s2_col_b_reg;
            s3_col_c_reg <= s2_col_c_reg;
            s3_tv_reg    <= s2_tv_reg;
        end
        if (stg_en[3])
        begin
            s4_det_reg <= s3_aabb_reg - s3_abab_reg;
            s4_na_reg  <= s3_ambb_reg - s3_bmab_reg;
            s4_nb_reg  <= s3_bmaa_reg - s3_amab_reg;
            s4_d1_reg  <= s4_d1_next;
            s4_d2_reg  <= s4_d2_next;
            s4_c3_reg  <= s4_c3_next;
            s4_tv_reg  <= s3_tv_reg;
        end
        if (stg_en[4])
        begin
            s5_t_reg   <= s5_t_next;
            s5_det_reg <= s4_det_reg;
            s5_ctl_reg <= s5_ctl_next;
        end
        if (stg_en[5])
        begin
            s6_den_reg <= s6_den_next;
            s6_rem_reg <= s6_rem_next;
            s6_ctl_reg <= s6_ctl_next;
        end
        if (stg_en[NS-1])
        begin
            out_col_reg   <= out_col_next;
            out_degen_reg <= fin_ctl.degen;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_red    = out_col_reg[0];
    assign out_green  = out_col_reg[1];
    assign out_blue   = out_col_reg[2];
    assign out_alpha  = out_col_reg[ALPHA_LANE];
    assign degenerate = out_degen_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A degenerate result always carries the pink red and green channels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> out_red == CMAX && out_green == '0)
        else $error("degenerate item without pink color");

    // The input side only stalls when the first stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_vld_reg)
        else $error("input stalled with an empty first stage");

    // An accepted item is in the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_vld_reg)
        else $error("accepted item lost at the first stage");

endmodule
`default_nettype wire
